// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file tsat_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define ASSERT_NOW(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Implication in the next cycle; cons may itself carry a ## delay.
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> cons) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- design/tsat_pkg.sv -----
// Package for the tiled summed area table: beat types and default constants.
// No dependencies.
package tsat_pkg;

  localparam int TILE_DEF       = 32;
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int PIXEL_BITS_DEF = 8;

  localparam int PIX_W       = 8;
  localparam int SUM_W       = 18;
  localparam int CFG_W       = 13;
  localparam int WIDTH_RESET = 4096;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } tsat_pixel_t;

  typedef struct packed {
    logic [SUM_W-1:0] tile_sum;
    logic             tile_corner;
  } tsat_result_t;

endpackage

// ----- design/tiled_summed_area_table.sv -----
// Tiled summed area table: pixel in, tile-local running area sum out.
// Depends on tsat_pkg.
//
//   channel  | dir | handshake                  | beat
//   pixel    | in  | pixel_valid / pixel_stall   | tsat_pixel_t
//   result   | out | result_valid / result_stall | tsat_result_t
//   config   | in  | cfg_write                   | cfg_data (image width)
//
// One pixel per cycle while pixel_stall is low; a pixel beat passes stage one, then the output register.
// Column store is one RAM with a registered read at pixel accept and a write as the beat
// leaves stage one; a write to the column being read in the same cycle is forwarded.
// Reset is synchronous; column store contents are not cleared.
// A result stall backs up into pixel_stall once stage one and the output register are full.
module tiled_summed_area_table #(
  parameter int TILE       = tsat_pkg::TILE_DEF,
  parameter int MAX_WIDTH  = tsat_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = tsat_pkg::PIXEL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [tsat_pkg::CFG_W-1:0] cfg_data,
  input  logic                      pixel_valid,
  output logic                      pixel_stall,
  input  tsat_pkg::tsat_pixel_t     pixel_beat,
  output logic                      result_valid,
  input  logic                      result_stall,
  output tsat_pkg::tsat_result_t    result_beat
);
  import tsat_pkg::*;

  localparam int PIX_EFF = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
  localparam int RP_MAX  = TILE * ((1 << PIX_EFF) - 1);
  localparam int RP_W    = $clog2(RP_MAX + 1);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WID_W   = $clog2(MAX_WIDTH + 1);
  localparam int TIC_W   = $clog2(TILE);
  localparam int W_RST   = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

  typedef struct packed {
    logic [COL_W-1:0] x;
    logic [RP_W-1:0]  rp;
    logic             first_row;
    logic             corner;
  } stage_t;

  // effective width, clamped at write time
  logic [WID_W-1:0] width;

  // position state
  logic [COL_W-1:0] col_pos;
  logic [TIC_W-1:0] col_in_tile;
  logic [TIC_W-1:0] row_in_tile;
  logic [RP_W-1:0]  row_partial;

  // stage one and output
  logic             s1_valid;
  stage_t           s1;
  logic [SUM_W-1:0] rd_data;
  logic             fwd_hit;
  logic [SUM_W-1:0] fwd_data;

  logic [SUM_W-1:0] col_mem [MAX_WIDTH];

  logic             accept;
  logic             s1_move;
  logic [COL_W-1:0] cur_x;
  logic [TIC_W-1:0] cur_cit;
  logic [TIC_W-1:0] cur_row;
  logic [RP_W-1:0]  rp_prev;
  logic [RP_W-1:0]  rp_next;
  logic             row_end;
  logic             tile_right;
  logic [SUM_W-1:0] s1_prior;
  logic [SUM_W-1:0] s1_sum;

  always_comb begin
    s1_move     = s1_valid && (!result_valid || !result_stall);
    pixel_stall = s1_valid && !s1_move;
    accept      = pixel_valid && !pixel_stall;

    // frame start clears position before the pixel is used
    cur_x   = pixel_beat.frame_start ? '0 : col_pos;
    cur_cit = pixel_beat.frame_start ? '0 : col_in_tile;
    cur_row = pixel_beat.frame_start ? '0 : row_in_tile;
    rp_prev = (pixel_beat.frame_start || cur_cit == '0) ? '0 : row_partial;
    rp_next = rp_prev + RP_W'(pixel_beat.pixel[PIX_EFF-1:0]);

    row_end    = (WID_W'(cur_x) + WID_W'(1)) >= width;
    tile_right = (cur_cit == TIC_W'(TILE - 1)) || row_end;

    s1_prior = fwd_hit ? fwd_data : rd_data;
    s1_sum   = s1.first_row ? SUM_W'(s1.rp) : (s1_prior + SUM_W'(s1.rp));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width <= WID_W'(W_RST);
    end else if (cfg_write) begin
      if (cfg_data == '0) begin
        width <= WID_W'(1);
      end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
        width <= WID_W'(MAX_WIDTH);
      end else begin
        width <= WID_W'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos     <= '0;
      col_in_tile <= '0;
      row_in_tile <= '0;
      row_partial <= '0;
    end else if (accept) begin
      row_partial <= rp_next;
      if (row_end) begin
        col_pos     <= '0;
        col_in_tile <= '0;
        row_in_tile <= (cur_row == TIC_W'(TILE - 1)) ? '0 : cur_row + TIC_W'(1);
      end else begin
        col_pos     <= cur_x + COL_W'(1);
        col_in_tile <= (cur_cit == TIC_W'(TILE - 1)) ? '0 : cur_cit + TIC_W'(1);
        row_in_tile <= cur_row;
      end
    end
  end

  // column store: write from stage one, registered read at accept
  always_ff @(posedge clk) begin
    if (s1_move) begin
      col_mem[s1.x] <= s1_sum;
    end
    if (accept) begin
      rd_data <= col_mem[cur_x];
    end
  end

  // same-column write in the accept cycle: width of one, or a frame start after column zero
  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_hit  <= s1_move && (s1.x == cur_x);
      fwd_data <= s1_sum;
      s1       <= '{x: cur_x, rp: rp_next, first_row: (cur_row == '0),
                    corner: tile_right && (cur_row == TIC_W'(TILE - 1))};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result_beat <= '{tile_sum: s1_sum, tile_corner: s1.corner};
    end
  end

endmodule

// ----- design/tsat_checker.sv -----
// Port-level checks for the tiled summed area table, bound to the top level.
// Depends on tsat_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tsat_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   pixel_valid,
  input logic                   pixel_stall,
  input logic                   result_valid,
  input logic                   result_stall,
  input tsat_pkg::tsat_result_t result_beat
);
  import tsat_pkg::*;

  logic pixel_taken;
  logic result_held;

  assign pixel_taken = pixel_valid && !pixel_stall;
  assign result_held = result_valid && result_stall;

  // a held result beat keeps its value
  `ASSERT_NEXT(a_result_hold, clk, rst, result_held, (result_valid && $stable(result_beat)))

  // reset empties the output
  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, (!result_valid))

  // every accepted pixel has a result showing after stage one and the output register
  `ASSERT_NEXT(a_result_follows, clk, rst, pixel_taken, (##1 result_valid))

  // input backs up only behind a stalled output
  `ASSERT_NOW(a_stall_cause, clk, rst, pixel_stall, result_held)

endmodule

bind tiled_summed_area_table tsat_checker u_tsat_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel_valid),
  .pixel_stall  (pixel_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_beat  (result_beat)
);
